>>> hw/rtl/swmm_pkg.sv
// swmm_pkg: shared types and constants of the sliding window min/max block.
// No dependencies.
package swmm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int LEN_BITS        = 7;
    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(1);

    // control part of the scan wave travelling down the cell chain
    typedef struct packed {
        logic valid;
        logic emit;
    } t_wave_ctl;

endpackage

>>> hw/rtl/swmm_cell.sv
// swmm_cell: one cell of the window chain; holds one sample and folds it into
// the passing min/max scan wave. Depends on swmm_pkg.
module swmm_cell #(
    parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF,
    parameter int REM_BITS    = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    input  logic [SAMPLE_BITS-1:0]   i_smp,
    output logic [SAMPLE_BITS-1:0]   o_smp,
    input  swmm_pkg::t_wave_ctl      i_ctl,
    input  logic [REM_BITS-1:0]      i_rem,
    input  logic [SAMPLE_BITS-1:0]   i_lo,
    input  logic [SAMPLE_BITS-1:0]   i_hi,
    output swmm_pkg::t_wave_ctl      o_ctl,
    output logic [REM_BITS-1:0]      o_rem,
    output logic [SAMPLE_BITS-1:0]   o_lo,
    output logic [SAMPLE_BITS-1:0]   o_hi
);
    import swmm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_smp;
    t_wave_ctl              r_ctl;
    logic [REM_BITS-1:0]    r_rem, n_rem;
    logic [SAMPLE_BITS-1:0] r_lo, n_lo;
    logic [SAMPLE_BITS-1:0] r_hi, n_hi;
    logic                   w_fold;

    assign w_fold = i_ctl.valid && (i_rem != '0);

    always_comb begin
        n_lo  = i_lo;
        n_hi  = i_hi;
        n_rem = i_rem;
        if (w_fold) begin
            n_rem = i_rem - REM_BITS'(1);
            if ($signed(r_smp) < $signed(i_lo)) begin
                n_lo = r_smp;
            end
            if ($signed(r_smp) > $signed(i_hi)) begin
                n_hi = r_smp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_smp <= i_smp;
        end
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
    end

    assign o_smp = r_smp;
    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_lo  = r_lo;
    assign o_hi  = r_hi;

endmodule

>>> hw/rtl/sliding_window_min_max.sv
// Sliding window min/max over a chain of WINDOW_MAX sample cells.
// A request is registered at the chain head, its scan wave crosses the cells, and the
// result is registered at the output. A new request is taken only after the last
// scan has crossed the chain and its result, if any, has left.
// Reset (synchronous, active low): fill count 0, window length 1, no scan
// in flight; stored samples are undefined until written.
module sliding_window_min_max #(
    parameter int WINDOW_MAX  = swmm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swmm_pkg::LEN_BITS-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_start_new,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_window_min,
    output logic signed [SAMPLE_BITS-1:0] o_window_max
);
    import swmm_pkg::*;

    localparam int RW = $clog2(WINDOW_MAX + 1);
    localparam int EW = (RW > LEN_BITS) ? RW : LEN_BITS;

    logic [LEN_BITS-1:0]    r_len;
    logic [RW-1:0]          r_fill, n_fill;
    logic [RW-1:0]          w_fill_base;
    logic [EW-1:0]          w_len_ext;
    logic [RW-1:0]          w_eff_len;
    logic                   w_accept;
    logic                   r_busy;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_lo, r_out_hi;

    t_wave_ctl              r_inj_ctl;
    logic [RW-1:0]          r_inj_rem;
    logic [SAMPLE_BITS-1:0] r_inj_smp;

    logic [SAMPLE_BITS-1:0] w_smp [0:WINDOW_MAX];
    t_wave_ctl              w_ctl [0:WINDOW_MAX];
    logic [RW-1:0]          w_rem [0:WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] w_lo  [0:WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] w_hi  [0:WINDOW_MAX];

    assign o_in_stall = r_busy || r_out_valid;
    assign w_accept   = i_in_valid && !o_in_stall;

    // effective window length, clamped to 1..WINDOW_MAX
    assign w_len_ext = EW'(r_len);
    always_comb begin
        if (r_len == '0) begin
            w_eff_len = RW'(1);
        end else if (w_len_ext > EW'(WINDOW_MAX)) begin
            w_eff_len = RW'(WINDOW_MAX);
        end else begin
            w_eff_len = RW'(w_len_ext);
        end
    end

    assign w_fill_base = i_start_new ? '0 : r_fill;
    always_comb begin
        n_fill = w_fill_base;
        if (w_fill_base < RW'(WINDOW_MAX)) begin
            n_fill = w_fill_base + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_inj_ctl   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_inj_ctl.valid <= w_accept;
            r_inj_ctl.emit  <= w_accept && (n_fill >= w_eff_len);
            if (w_accept) begin
                r_fill <= n_fill;
                r_busy <= 1'b1;
            end else if (w_ctl[WINDOW_MAX].valid) begin
                r_busy <= 1'b0;
            end
            if (w_ctl[WINDOW_MAX].valid && w_ctl[WINDOW_MAX].emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_inj_rem <= w_eff_len;
            r_inj_smp <= i_sample;
        end
        if (w_ctl[WINDOW_MAX].valid && w_ctl[WINDOW_MAX].emit) begin
            r_out_lo <= w_lo[WINDOW_MAX];
            r_out_hi <= w_hi[WINDOW_MAX];
        end
    end

    assign w_smp[0] = i_sample;
    assign w_ctl[0] = r_inj_ctl;
    assign w_rem[0] = r_inj_rem;
    assign w_lo[0]  = r_inj_smp;
    assign w_hi[0]  = r_inj_smp;

    // cell k holds the sample of age k; the wave folds it while samples remain
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        swmm_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .REM_BITS   (RW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(w_accept),
            .i_smp  (w_smp[k]),
            .o_smp  (w_smp[k+1]),
            .i_ctl  (w_ctl[k]),
            .i_rem  (w_rem[k]),
            .i_lo   (w_lo[k]),
            .i_hi   (w_hi[k]),
            .o_ctl  (w_ctl[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_lo   (w_lo[k+1]),
            .o_hi   (w_hi[k+1])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_min = r_out_lo;
    assign o_window_max = r_out_hi;

endmodule

>>> hw/rtl/swmm_checker.sv
// swmm_checker: port-level checks of sliding_window_min_max, bound to the top.
// Depends on swmm_pkg and sliding_window_min_max.
module swmm_checker #(
    parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [SAMPLE_BITS-1:0] o_window_min,
    input logic signed [SAMPLE_BITS-1:0] o_window_max
);
    import swmm_pkg::*;

    // held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_window_min) && $stable(o_window_max))
        else $error("result changed while stalled");

    // one request in flight: a taken request closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken during scan");

    a_no_take_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_window_min <= o_window_max))
        else $error("window minimum above maximum");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sliding_window_min_max swmm_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_swmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_window_min(o_window_min),
    .o_window_max(o_window_max)
);

>>> tb/testbench.sv
// testbench: self-checking bench for sliding_window_min_max. Directed and random requests,
// each result checked against a window min/max predictor held in a scoreboard class.
// Depends on swmm_pkg and the sliding_window_min_max block.
module testbench;
    import swmm_pkg::*;

    localparam int DEPTH           = WINDOW_MAX_DEF;
    localparam int SMP_W           = SAMPLE_BITS_DEF;
    localparam int DRAIN_WAIT      = DEPTH + 16;
    localparam int LONG_HOLD       = 400;
    localparam int MAX_GAP         = 14;
    localparam int RANDOM_REQUESTS = 600;

    typedef logic signed [SMP_W-1:0] t_sample;
    typedef logic [LEN_BITS-1:0]     t_len;
    typedef struct packed {
        t_sample lo;
        t_sample hi;
    } t_minmax;

    localparam t_sample MOST_NEG = {1'b1, {(SMP_W-1){1'b0}}};
    localparam t_sample MOST_POS = {1'b0, {(SMP_W-1){1'b1}}};

    class t_window_tracker;
        t_sample     store [DEPTH];
        int unsigned fill;
        int unsigned wr_idx;
        t_len        len_reg;
        t_minmax     expected_minmax [$];
        int          errors;
        int          checked;

        function void clear();
            foreach (store[k]) store[k] = '0;
            fill    = 0;
            wr_idx  = 0;
            len_reg = LEN_RESET;
            expected_minmax.delete();
        endfunction

        function void set_len(t_len v);
            len_reg = v;
        endfunction

        function int pending();
            return expected_minmax.size();
        endfunction

        function void note_sample(t_sample smp, logic restart);
            int unsigned span;
            int unsigned pos;
            t_minmax     r;
            if (restart) fill = 0;
            store[wr_idx] = smp;
            wr_idx = (wr_idx + 1) % DEPTH;
            if (fill < DEPTH) fill++;
            // zero acts as one, anything past the store depth saturates
            span = (len_reg == 0) ? 1 : ((len_reg > DEPTH) ? DEPTH : len_reg);
            if (fill < span) return;
            r.lo = smp;
            r.hi = smp;
            pos  = wr_idx;
            repeat (span) begin
                pos = (pos == 0) ? DEPTH - 1 : pos - 1;
                if (store[pos] < r.lo) r.lo = store[pos];
                if (store[pos] > r.hi) r.hi = store[pos];
            end
            expected_minmax.insert(expected_minmax.size(), r);
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH %s", $time, what);
            errors++;
        endtask

        task check_minmax(t_sample lo, t_sample hi);
            t_minmax want;
            if (expected_minmax.size() == 0) begin
                report($sformatf("unexpected result: min %0d max %0d", lo, hi));
                return;
            end
            want = expected_minmax.pop_front();
            checked++;
            if (lo !== want.lo) report($sformatf("window_min %0d, want %0d", lo, want.lo));
            if (hi !== want.hi) report($sformatf("window_max %0d, want %0d", hi, want.hi));
        endtask

        task close_out();
            if (expected_minmax.size() != 0) begin
                report($sformatf("%0d expected results never arrived", expected_minmax.size()));
            end
        endtask
    endclass

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_cfg_we    = 1'b0;
    t_len    i_cfg_wdata = '0;
    logic    i_in_valid  = 1'b0;
    t_sample i_sample    = '0;
    logic    i_start_new = 1'b0;
    logic    i_out_stall = 1'b0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_sample o_window_min;
    t_sample o_window_max;

    t_window_tracker tracker;
    logic tx_quiet = 1'b0;
    logic rx_quiet = 1'b0;
    logic rx_hold  = 1'b0;
    logic hold_go  = 1'b0;
    int   rx_wait  = 0;
    int   sent     = 0;
    int   len_writes = 0;

    sliding_window_min_max #(
        .WINDOW_MAX  (DEPTH),
        .SAMPLE_BITS (SMP_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_start_new  (i_start_new),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_window_min (o_window_min),
        .o_window_max (o_window_max)
    );

    always #5 i_clk = ~i_clk;

    // results first: a result always belongs to an earlier request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) tracker.check_minmax(o_window_min, o_window_max);
            if (i_in_valid && !o_in_stall) tracker.note_sample(i_sample, i_start_new);
        end
    end

    // receiver: holds each result for a random number of cycles before taking it
    always @(posedge i_clk) begin
        if (rx_hold) begin
            i_out_stall <= 1'b1;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end else if (o_out_valid && rx_wait != 0) begin
                rx_wait = rx_wait - 1;
            end
            i_out_stall <= (rx_wait != 0);
        end
    end

    initial begin : long_hold
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                return MOST_NEG;
            end
            1: begin
                return MOST_POS;
            end
            2, 3: begin
                return t_sample'(int'($urandom_range(0, 16)) - 8);
            end
            default: begin
                return t_sample'($urandom);
            end
        endcase
    endfunction

    task automatic send_sample(t_sample smp, logic restart);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample    <= smp;
        i_start_new <= restart;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    // stop offering, let every expected result out, then cover a request with no result
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_window_len(t_len v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_len(v);
        len_writes++;
    endtask

    initial begin : stimulus
        t_len len_plan [6] = '{t_len'(1), t_len'(64), t_len'(127), t_len'(65), t_len'(0),
                               t_len'(2)};
        t_len len_now;
        int   phase;
        int   phase_len;
        int   base;
        tracker = new();
        tracker.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window of one after reset: each request answers with itself
        send_sample(MOST_NEG, 1'b1);
        send_sample(MOST_POS, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        // length zero behaves as one
        write_window_len(t_len'(0));
        send_sample(t_sample'(32'h5555_5555), 1'b0);
        send_sample(t_sample'(32'hAAAA_AAAA), 1'b0);
        write_window_len(t_len'(3));
        send_sample(MOST_POS, 1'b1);
        send_sample(t_sample'(-7), 1'b0);
        send_sample(MOST_NEG, 1'b0);
        // restart mid-stream: window refills before the next result
        send_sample(t_sample'(12), 1'b1);
        send_sample(t_sample'(12), 1'b0);
        send_sample(t_sample'(-12), 1'b0);
        // length change without restart keeps the history
        write_window_len(t_len'(5));
        send_sample(t_sample'(3), 1'b0);
        send_sample(MOST_POS, 1'b0);
        write_window_len(t_len'(2));
        send_sample(MOST_NEG, 1'b0);

        base  = sent;
        phase = 0;
        while (sent - base < RANDOM_REQUESTS) begin
            if (phase < 6) begin
                len_now = len_plan[phase];
            end else if ($urandom_range(0, 3) == 0) begin
                len_now = t_len'($urandom_range(0, 127));
            end else begin
                len_now = t_len'($urandom_range(1, 8));
            end
            write_window_len(len_now);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            phase_len = (len_now > 8) ? $urandom_range(70, 100) : $urandom_range(15, 40);
            for (int k = 0; k < phase_len; k++) begin
                // window of one: every request yields a result, so a long hold backs up
                if (phase == 0 && k == 10) hold_go = 1'b1;
                if (phase == 4 && k == phase_len / 2) settle();
                send_sample(pick_sample(),
                            (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0));
            end
            phase++;
        end

        settle();
        tracker.close_out();
        $display("Sent %0d requests over %0d window length settings;", sent, len_writes);
        $display("%0d min/max results checked.", tracker.checked);
        if (tracker.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> sliding_window_min_max.f
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_cell.sv
hw/rtl/sliding_window_min_max.sv
hw/rtl/swmm_checker.sv
tb/testbench.sv
